// ----- hdl/bws_pkg.sv -----
package bws_pkg;

  // Width of the order register and of the index field on the result channel
  localparam int unsigned ORD_W = 4;
  localparam int unsigned IDX_W = 3;

  // Order after reset
  localparam logic [ORD_W-1:0] ORDER_RESET = ORD_W'(4);
  localparam logic [ORD_W-1:0] ORDER_MIN   = ORD_W'(2);

endpackage

// ----- hdl/bws_front.sv -----
module bws_front import bws_pkg::*; #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ORD_W-1:0]     cfg_spline_order,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS-1:0] in_frac_coord,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [FRAC_BITS+ORD_W-1:0] q_data
);

  localparam logic [ORD_W-1:0] ORDER_MAX = ORD_W'(MAX_ORDER);

  logic [ORD_W-1:0] order_r;
  logic [ORD_W-1:0] order_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      order_r <= cfg_spline_order;
    end
  end

  // clamp order into the supported range
  always_comb begin
    priority if (order_r < ORDER_MIN) begin
      order_eff = ORDER_MIN;
    end else if (order_r > ORDER_MAX) begin
      order_eff = ORDER_MAX;
    end else begin
      order_eff = order_r;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {order_eff, in_frac_coord};

endmodule

// ----- hdl/bws_queue.sv -----
module bws_queue import bws_pkg::*; #(
  parameter int unsigned W = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/bws_back.sv -----
module bws_back import bws_pkg::*; #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  logic [FRAC_BITS+ORD_W-1:0] q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_weight_index,
  output logic [FRAC_BITS:0]   out_weight,
  output logic signed [FRAC_BITS+1:0] out_slope,
  output logic                 out_last_of_run
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned IW = $clog2(MAX_ORDER);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned MW = F + IW;
  localparam int unsigned PW = F + 1 + MW;
  localparam int unsigned XW = PW + 1 - F;
  localparam int unsigned K  = XW;
  localparam logic [F:0]  ONE_Q = {1'b1, {F{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_LEVEL, S_MUL, S_SHIFT, S_RECIP, S_CORR, S_EMIT
  } state_t;

  state_t             state_r;
  logic [F-1:0]       frac_r;
  logic [ORD_W-1:0]   ord_r;
  logic [NW-1:0]      lvl_r;
  logic [IW-1:0]      pos_r;
  logic [IW-1:0]      k_r;
  logic [F:0]         w_r   [MAX_ORDER];
  logic [F:0]         low_r [MAX_ORDER];
  logic [XW-1:0]      carry_r;
  logic [PW-1:0]      prod_up_r, prod_dn_r;
  logic [XW-1:0]      x_up_r, x_dn_r;
  logic [XW-1:0]      qm_up_r, qm_dn_r;
  logic [F:0]         prev_hi_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   idx_r;
  logic [F:0]         weight_r;
  logic [F+1:0]       slope_r;
  logic               last_r;

  // reciprocal table: floor(2^K / d) for each divisor d
  logic [K:0] recip [MAX_ORDER];
  assign recip[0] = '0;
  for (genvar j = 1; j < MAX_ORDER; j++) begin : g_recip
    localparam logic [63:0] RV = (64'(1) << K) / 64'(j);
    assign recip[j] = RV[K:0];
  end

  logic [IW-1:0]   d_cur;
  logic [IW-1:0]   rd_idx;
  logic [F:0]      w_rd;
  logic [MW-1:0]   m_up, m_dn;
  logic [PW:0]     bias;
  logic [PW:0]     sum_up_b, sum_dn_b;
  logic [XW+K:0]   rq_up, rq_dn;
  logic [XW-1:0]   rem_up, rem_dn;
  logic [XW-1:0]   up_t, dn_t;
  logic [XW:0]     wsum;
  logic [F:0]      wsat, dsat;
  logic            emit_go;
  logic            emit_fire;
  logic [F:0]      hi_v;

  assign d_cur  = IW'(lvl_r - NW'(1));
  assign rd_idx = (state_r == S_EMIT) ? k_r : pos_r;
  assign w_rd   = w_r[rd_idx];
  assign m_up   = {pos_r, frac_r};
  assign m_dn   = {IW'(d_cur - pos_r), {F{1'b0}}} - MW'(frac_r);
  assign bias   = (PW+1)'(d_cur) << (F - 1);
  assign sum_up_b = {1'b0, prod_up_r} + bias;
  assign sum_dn_b = {1'b0, prod_dn_r} + bias;
  assign rq_up  = (XW+K+1)'(x_up_r) * (XW+K+1)'(recip[d_cur]);
  assign rq_dn  = (XW+K+1)'(x_dn_r) * (XW+K+1)'(recip[d_cur]);
  assign rem_up = x_up_r - XW'(qm_up_r * XW'(d_cur));
  assign rem_dn = x_dn_r - XW'(qm_dn_r * XW'(d_cur));
  assign up_t   = qm_up_r + XW'(rem_up >= XW'(d_cur));
  assign dn_t   = qm_dn_r + XW'(rem_dn >= XW'(d_cur));
  assign wsum   = {1'b0, carry_r} + {1'b0, up_t};
  assign wsat   = (wsum > (XW+1)'(ONE_Q)) ? ONE_Q : wsum[F:0];
  assign dsat   = (dn_t > XW'(ONE_Q)) ? ONE_Q : dn_t[F:0];
  assign emit_go = !out_valid_r || !out_stall;
  assign emit_fire = (state_r == S_EMIT) && emit_go;
  assign hi_v   = ((ORD_W'(k_r) + ORD_W'(1)) < ord_r) ? low_r[k_r] : '0;
  assign q_pop  = (state_r == S_IDLE) && q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result, or drop the held one once it is taken
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            frac_r  <= q_data[F-1:0];
            ord_r   <= q_data[F+ORD_W-1:F];
            w_r[0]  <= ONE_Q;
            lvl_r   <= NW'(2);
            state_r <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          if (ORD_W'(lvl_r) == ord_r) begin
            low_r <= w_r;
          end
          pos_r   <= '0;
          carry_r <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_up_r <= PW'(w_rd) * PW'(m_up);
          prod_dn_r <= PW'(w_rd) * PW'(m_dn);
          state_r   <= S_SHIFT;
        end
        S_SHIFT: begin
          x_up_r  <= XW'(sum_up_b >> F);
          x_dn_r  <= XW'(sum_dn_b >> F);
          state_r <= S_RECIP;
        end
        S_RECIP: begin
          qm_up_r <= XW'(rq_up >> K);
          qm_dn_r <= XW'(rq_dn >> K);
          state_r <= S_CORR;
        end
        S_CORR: begin
          w_r[pos_r] <= wsat;
          carry_r    <= dn_t;
          if (NW'(pos_r) == lvl_r - NW'(2)) begin
            w_r[IW'(lvl_r - NW'(1))] <= dsat;
            if (ORD_W'(lvl_r) == ord_r) begin
              k_r       <= '0;
              prev_hi_r <= '0;
              state_r   <= S_EMIT;
            end else begin
              lvl_r   <= lvl_r + NW'(1);
              state_r <= S_LEVEL;
            end
          end else begin
            pos_r   <= pos_r + IW'(1);
            state_r <= S_MUL;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            idx_r       <= IDX_W'(k_r);
            weight_r    <= w_rd;
            slope_r     <= {1'b0, hi_v} - {1'b0, prev_hi_r};
            last_r      <= (ORD_W'(k_r) + ORD_W'(1) == ord_r);
            prev_hi_r   <= hi_v;
            k_r         <= k_r + IW'(1);
            if (ORD_W'(k_r) + ORD_W'(1) == ord_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_weight_index = idx_r;
  assign out_weight       = weight_r;
  assign out_slope        = $signed(slope_r);
  assign out_last_of_run  = last_r;

endmodule

// ----- hdl/bspline_weight_and_slope_set_unit.sv -----
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------------------
// input     | in_valid/in_stall  | in_frac_coord
// result    | out_valid/out_stall| out_weight_index, out_weight, out_slope,
//           |                    | out_last_of_run
// config    | cfg_valid/cfg_ready| cfg_spline_order
//
// For order N the back end runs each recurrence term through one shared
// pair of multiply / reciprocal-divide paths in four steps, then emits N
// results.
// Reset (synchronous, rst_n low) empties the queue, idles the back end and
// loads order 4. A two-deep queue lets the front accept coordinates while the
// back end works or is held by out_stall; in_stall rises only when it is full.
module bspline_weight_and_slope_set_unit import bws_pkg::*; #(
  parameter int unsigned MAX_ORDER = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ORD_W-1:0]     cfg_spline_order,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS-1:0] in_frac_coord,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_weight_index,
  output logic [FRAC_BITS:0]   out_weight,
  output logic signed [FRAC_BITS+1:0] out_slope,
  output logic                 out_last_of_run
);

  localparam int unsigned QW = FRAC_BITS + ORD_W;

  logic          q_full, q_push, q_pop, q_not_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  // accept coordinate, clamp order, hand transaction to the queue
  bws_front #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_spline_order,
    .in_valid, .in_stall, .in_frac_coord,
    .q_full, .q_push, .q_data(q_wdata)
  );

  bws_queue #(.W(QW)) u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .pop_data(q_rdata)
  );

  // build the weights level by level, then stream the run
  bws_back #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_not_empty, .q_data(q_rdata), .q_pop,
    .out_valid, .out_stall, .out_weight_index, .out_weight, .out_slope,
    .out_last_of_run
  );

endmodule

// ----- tb/sv/bspline_weight_and_slope_set_unit_test.sv -----
`timescale 1ns / 1ps

import bws_pkg::*;

typedef struct packed {
  logic [2:0]  idx;
  logic [16:0] weight;
  logic [17:0] slope;
  logic        last;
} spline_term_t;

class spline_set_scoreboard;
  spline_term_t     expected_terms[$];
  logic [ORD_W-1:0] order_reg;
  int               errors;

  function new();
    order_reg = ORDER_RESET;
    errors    = 0;
  endfunction

  // Round (w + r/2^16) / d to nearest, ties up
  static function longint unsigned div_round(longint unsigned w, longint unsigned r,
                                             longint unsigned d);
    longint unsigned num;
    num = ((w % d) << 16) + r + d * 32768;
    return w / d + num / (d << 16);
  endfunction

  // Weights of one recurrence level for fraction f
  static function void spline_level(int lvl, longint unsigned f,
                                     output longint unsigned w[8]);
    longint unsigned d, carry, v, p, q, r, up, c, dn, sum;
    for (int i = 0; i < 8; i++) w[i] = 0;
    w[0] = 65536;
    for (int n = 2; n <= lvl; n++) begin
      d = n - 1;
      carry = 0;
      for (int i = 0; i + 1 < n; i++) begin
        v  = w[i];
        p  = f * v;
        q  = p >> 16;
        r  = p & 16'hFFFF;
        up = div_round(i * v + q, r, d);
        c  = (d - i) * v - q;
        dn = (r == 0) ? div_round(c, 0, d) : div_round(c - 1, 65536 - r, d);
        sum = carry + up;
        w[i] = (sum > 65536) ? 65536 : sum;
        carry = dn;
      end
      w[n-1] = (carry > 65536) ? 65536 : carry;
    end
  endfunction

  // Work out the whole run of weights and slopes for one coordinate
  function void note_coord(logic [15:0] frac);
    longint unsigned wts[8], low[8], hi, lo;
    int ord;
    spline_term_t t;
    ord = int'(order_reg);
    if (ord < 2) ord = 2;
    if (ord > 8) ord = 8;
    spline_level(ord, frac, wts);
    spline_level(ord - 1, frac, low);
    for (int k = 0; k < ord; k++) begin
      hi = (k + 1 < ord) ? low[k] : 0;
      lo = (k > 0) ? low[k-1] : 0;
      t.idx    = 3'(k);
      t.weight = 17'(wts[k]);
      t.slope  = 18'(hi - lo);
      t.last   = (k + 1 == ord);
      expected_terms.push_back(t);
    end
  endfunction

  function void check_result(spline_term_t got);
    spline_term_t exp_t;
    if (expected_terms.size() == 0) begin
      $error("result with nothing expected: index %0d", got.idx);
      errors++;
      return;
    end
    exp_t = expected_terms.pop_front();
    if (got.idx !== exp_t.idx) begin
      $error("weight_index: expected %0d, got %0d", exp_t.idx, got.idx);
      errors++;
    end
    if (got.weight !== exp_t.weight) begin
      $error("weight: expected %0d, got %0d", exp_t.weight, got.weight);
      errors++;
    end
    if (got.slope !== exp_t.slope) begin
      $error("slope: expected %0d, got %0d", $signed(exp_t.slope), $signed(got.slope));
      errors++;
    end
    if (got.last !== exp_t.last) begin
      $error("last_of_run: expected %0d, got %0d", exp_t.last, got.last);
      errors++;
    end
  endfunction
endclass

module bspline_weight_and_slope_set_unit_test;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ORD_W-1:0] cfg_spline_order = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_frac_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_weight_index;
  logic [16:0] out_weight;
  logic signed [17:0] out_slope;
  logic out_last_of_run;

  spline_set_scoreboard sb = new();
  bit calm = 1'b0;       // no idling on either side when set
  bit long_hold = 1'b0;  // request for a long receiver hold-off
  int cycles = 0;

  bspline_weight_and_slope_set_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_spline_order(cfg_spline_order),
    .in_valid(in_valid), .in_stall(in_stall), .in_frac_coord(in_frac_coord),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_weight_index(out_weight_index), .out_weight(out_weight),
    .out_slope(out_slope), .out_last_of_run(out_last_of_run)
  );

  always #10 clk = ~clk;

  // Abort the run if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check every accepted result transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_weight_index, out_weight, out_slope, out_last_of_run});
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && rst_n && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one coordinate transaction; hold valid high unless a gap follows
  task automatic send_coord(logic [15:0] frac);
    in_valid      <= 1'b1;
    in_frac_coord <= frac;
    do @(posedge clk); while (in_stall);
    sb.note_coord(frac);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_terms.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_order(logic [ORD_W-1:0] ord);
    drain();
    cfg_valid        <= 1'b1;
    cfg_spline_order <= ord;
    do @(posedge clk); while (!cfg_ready);
    sb.order_reg = ord;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly uniform coordinates, with some near the ends of the range
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 15));
      1: return 16'($urandom_range(65520, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  logic [ORD_W-1:0] phase_orders[10] = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd3,
                                         4'd5, 4'd6, 4'd7, 4'd1, 4'd9};
  logic [15:0]      edge_coords[8] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF,
                                       16'h7FFF, 16'h5555, 16'hAAAA, 16'h4000};

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extreme and patterned coordinates at the reset order
    foreach (edge_coords[i]) send_coord(edge_coords[i]);

    foreach (phase_orders[p]) begin
      write_order(phase_orders[p]);
      // Boundary and out-of-range orders get edge coordinates too
      if (p < 4)
        for (int i = 0; i < 3; i++) send_coord(edge_coords[i + p]);
      if (p == 1) long_hold = 1'b1;
      if (p == 9) calm = 1'b1;
      for (int i = 0; i < 48; i++) begin
        send_coord(pick_coord());
        if (p == 2 && i == 20) drain();
      end
    end
    write_order(ORD_W'(15));
    for (int i = 0; i < 8; i++) send_coord(pick_coord());

    drain();
    repeat (300) @(negedge clk);
    if (sb.errors == 0 && sb.expected_terms.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bws_pkg.sv
hdl/bws_front.sv
hdl/bws_queue.sv
hdl/bws_back.sv
hdl/bspline_weight_and_slope_set_unit.sv
tb/sv/bspline_weight_and_slope_set_unit_test.sv
